[sv/epoch_seconds_to_calendar_core_macros.svh]
// assertion macros shared by the converter modules
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH

// condition must hold on every edge out of reset
`define EPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define EPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/epc_pkg.sv]
`timescale 1ns / 1ps

package epc_pkg;

  // field widths
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  // internal widths
  localparam int unsigned Q1_W   = 27;  // seconds / 60
  localparam int unsigned Q2_W   = 21;  // seconds / 3600
  localparam int unsigned DAYS_W = 16;  // whole days since the epoch
  localparam int unsigned DOY_W  = 9;   // day of the march-based year, offset by 30
  localparam int unsigned YIDX_W = 8;   // year index from 1969

  // calendar constants
  localparam int unsigned ERA_OFFSET_DAYS   = 719499;
  localparam int unsigned SEARCH_START_YEAR = 1969;
  localparam int unsigned MONTH_NUM         = 367;
  localparam int unsigned DAYS_PER_YEAR     = 365;
  localparam int unsigned MARCH_SHIFT       = 30;
  localparam int unsigned MONTHS            = 12;
  localparam int unsigned MONTH_SHIFT       = 2;   // march-based month to january-based

  // reciprocals for division by constants, exact over the ranges in use
  localparam logic [31:0] RECIP_60_A  = 32'h8888_8889;   // 32-bit value / 60, shift 37
  localparam int unsigned SHIFT_60_A  = 37;
  localparam logic [27:0] RECIP_60_B  = 28'd143165577;   // 27-bit value / 60, shift 33
  localparam int unsigned SHIFT_60_B  = 33;
  localparam logic [17:0] RECIP_3     = 18'd174763;      // 18-bit value / 3, shift 19
  localparam int unsigned SHIFT_3     = 19;
  localparam logic [15:0] RECIP_366   = 16'd45840;       // 16-bit value / 366, shift 24
  localparam int unsigned SHIFT_366   = 24;

  // whole-year day count with the 4/100/400 leap rules
  function automatic int unsigned days_before_year(int unsigned y);
    return y * DAYS_PER_YEAR + y / 4 - y / 100 + y / 400;
  endfunction

  localparam int unsigned DBY_START = days_before_year(SEARCH_START_YEAR);

  // bias taking whole days to the search variable (day count minus start year minus shift)
  localparam logic [DAYS_W-1:0] DAY_BIAS =
    DAYS_W'(ERA_OFFSET_DAYS - DBY_START - MARCH_SHIFT);

  // year table: days from the start year to the start of each later year
  localparam int unsigned YEAR_SPAN = 138;
  typedef logic [DAYS_W-1:0] year_off_tab_t [YEAR_SPAN];

  function automatic year_off_tab_t build_year_off();
    year_off_tab_t tab;
    for (int j = 0; j < YEAR_SPAN; j++) begin
      tab[j] = DAYS_W'(days_before_year(SEARCH_START_YEAR + j) - DBY_START);
    end
    return tab;
  endfunction

  localparam year_off_tab_t YEAR_OFF = build_year_off();

  // month boundaries 367*m/12 of the march-based year
  typedef logic [DOY_W-1:0] month_tab_t [MONTHS+1];

  function automatic month_tab_t build_month_start();
    month_tab_t tab;
    for (int m = 0; m <= MONTHS; m++) begin
      tab[m] = DOY_W'((MONTH_NUM * m) / 12);
    end
    return tab;
  endfunction

  localparam month_tab_t MONTH_START = build_month_start();

  // time of day plus day count, between the two halves
  typedef struct packed {
    logic [DAYS_W-1:0]   days;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } epc_tod_t;

  // full calendar result
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } epc_cal_t;

endpackage

[sv/epc_if.sv]
`timescale 1ns / 1ps

// timestamp channel
interface epc_in_if;
  import epc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [EPOCH_W-1:0]   epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// calendar channel
interface epc_out_if;
  import epc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day;
  logic [HOUR_W-1:0]    hour;
  logic [MINUTE_W-1:0]  minute;
  logic [SECOND_W-1:0]  second;
  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

[sv/epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps

// Converts a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian year, month, day, hour, minute and second. Every input value gives a valid
// date, the last being 2106-02-07 06:28:15. The converter is an eleven-stage pipeline
// that takes one word per cycle while nothing stalls and holds no state between words.
// Its depth is set by the chain of reciprocal multiplies (by 60 and 60, then by 3 after a
// divide by 8, for the time of day, by 366 for the year estimate), the year-table
// correction and the month boundary compare, each with a stage of its own. Backpressure
// stalls only the stages that are full, so bubbles close up and the input keeps flowing
// while a result waits at the output, until the pipe has filled.
module epoch_seconds_to_calendar_core (
  input  logic       clk,
  input  logic       rst,
  epc_in_if.sink     stamp,
  epc_out_if.source  calendar
);
  import epc_pkg::*;

  logic     tod_valid;
  logic     tod_ready;
  epc_tod_t tod;
  epc_cal_t cal;

  // time of day and day count
  epc_time_split u_time_split (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (stamp.valid),
    .up_ready      (stamp.ready),
    .epoch_seconds (stamp.epoch_seconds),
    .dn_valid      (tod_valid),
    .dn_ready      (tod_ready),
    .tod           (tod)
  );

  // year, month and day
  epc_date_calc u_date_calc (
    .clk      (clk),
    .rst      (rst),
    .up_valid (tod_valid),
    .up_ready (tod_ready),
    .tod      (tod),
    .dn_valid (calendar.valid),
    .dn_ready (calendar.ready),
    .cal      (cal)
  );

  assign calendar.year   = cal.year;
  assign calendar.month  = cal.month;
  assign calendar.day    = cal.day;
  assign calendar.hour   = cal.hour;
  assign calendar.minute = cal.minute;
  assign calendar.second = cal.second;

endmodule

[sv/epc_time_split.sv]
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_core_macros.svh"

module epc_time_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [epc_pkg::EPOCH_W-1:0]   epoch_seconds,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output epc_pkg::epc_tod_t             tod
);
  import epc_pkg::*;

  localparam int unsigned STAGES = 5;
  localparam int unsigned LAST   = STAGES - 1;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  // stage registers
  logic [EPOCH_W-1:0]  x0;
  logic [EPOCH_W-1:0]  x1;
  logic [Q1_W-1:0]     q1_1;
  logic [Q1_W-1:0]     q1_2;
  logic [Q2_W-1:0]     q2_2;
  logic [SECOND_W-1:0] sec2;
  logic [SECOND_W-1:0] sec3;
  logic [MINUTE_W-1:0] min3;
  logic [Q2_W-1:0]     q2_3;
  logic [DAYS_W-1:0]   days3;
  epc_tod_t            tod4;

  // next values
  logic [2*EPOCH_W-1:0]      prod1;
  logic [Q1_W+28-1:0]        prod2;
  logic [35:0]               prod3;
  logic [EPOCH_W-1:0]        q1_ext;
  logic [EPOCH_W-1:0]        sec_rem;
  logic [Q1_W-1:0]           q2_ext;
  logic [Q1_W-1:0]           min_rem;
  logic [Q2_W-1:0]           days_ext;
  logic [Q2_W-1:0]           hour_rem;
  logic [Q1_W-1:0]           q1_next;
  logic [Q2_W-1:0]           q2_next;
  logic [SECOND_W-1:0]       sec_next;
  logic [MINUTE_W-1:0]       min_next;
  logic [DAYS_W-1:0]         days_next;
  epc_tod_t                  tod_next;

  // backpressure: a stage moves when it is empty or the next one moves
  always_comb begin
    en[LAST] = !v[LAST] || dn_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // seconds / 60
  always_comb begin
    prod1   = (2*EPOCH_W)'(x0) * (2*EPOCH_W)'(RECIP_60_A);
    q1_next = prod1[SHIFT_60_A +: Q1_W];
  end

  // second of minute, and minutes / 60
  always_comb begin
    q1_ext   = EPOCH_W'(q1_1);
    sec_rem  = x1 - ((q1_ext << 6) - (q1_ext << 2));
    sec_next = sec_rem[SECOND_W-1:0];
    prod2    = (Q1_W+28)'(q1_1) * (Q1_W+28)'(RECIP_60_B);
    q2_next  = prod2[SHIFT_60_B +: Q2_W];
  end

  // minute of hour, and hours / 24 as (hours / 8) / 3
  always_comb begin
    q2_ext    = Q1_W'(q2_2);
    min_rem   = q1_2 - ((q2_ext << 6) - (q2_ext << 2));
    min_next  = min_rem[MINUTE_W-1:0];
    prod3     = 36'(q2_2[Q2_W-1:3]) * 36'(RECIP_3);
    days_next = prod3[SHIFT_3 +: DAYS_W];
  end

  // hour of day
  always_comb begin
    days_ext        = Q2_W'(days3);
    hour_rem        = q2_3 - ((days_ext << 4) + (days_ext << 3));
    tod_next.days   = days3;
    tod_next.hour   = hour_rem[HOUR_W-1:0];
    tod_next.minute = min3;
    tod_next.second = sec3;
  end

  always_ff @(posedge clk) begin
    if (en[0]) x0 <= epoch_seconds;
    if (en[1]) begin
      x1   <= x0;
      q1_1 <= q1_next;
    end
    if (en[2]) begin
      q1_2 <= q1_1;
      q2_2 <= q2_next;
      sec2 <= sec_next;
    end
    if (en[3]) begin
      sec3  <= sec2;
      min3  <= min_next;
      q2_3  <= q2_2;
      days3 <= days_next;
    end
    if (en[4]) tod4 <= tod_next;
  end

  assign up_ready = en[0];
  assign dn_valid = v[LAST];
  assign tod      = tod4;

  // checks
  `EPC_ASSERT_NXT(a_enter, up_valid && up_ready, v[0], "accepted word did not enter the pipe")
  `EPC_ASSERT_IMP(a_drain_ready, !dn_valid, up_ready, "empty output stage but input stalled")
  `EPC_ASSERT_IMP(a_sec_range, v[2], sec2 < 6'd60, "second remainder out of range")
  `EPC_ASSERT_IMP(a_tod_range, dn_valid, (tod.minute < 6'd60) && (tod.hour < 5'd24),
                  "minute or hour out of range")

endmodule

[sv/epc_date_calc.sv]
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_core_macros.svh"

module epc_date_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  epc_pkg::epc_tod_t    tod,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output epc_pkg::epc_cal_t    cal
);
  import epc_pkg::*;

  localparam int unsigned STAGES = 6;
  localparam int unsigned LAST   = STAGES - 1;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  // stage registers
  epc_tod_t            tod0, tod1, tod2, tod3, tod4;
  logic [DAYS_W-1:0]   e0, e1, e2;
  logic [DAYS_W-1:0]   em1_0;
  logic [YIDX_W-1:0]   j0_1, j0_2;
  logic [DAYS_W-1:0]   off_lo2, off_hi2;
  logic [YEAR_W-1:0]   yr3, yr4;
  logic [DOY_W-1:0]    t3, t4;
  logic [MONTH_W-1:0]  mon4;
  epc_cal_t            cal5;

  // next values
  logic [2*DAYS_W-1:0] prod4;
  logic [YIDX_W-1:0]   j0_next;
  logic [YIDX_W-1:0]   j0_inc;
  logic                take_hi;
  logic [YIDX_W-1:0]   j_sel;
  logic [DAYS_W-1:0]   off_sel;
  logic [DAYS_W:0]     t_wide;
  logic [MONTH_W-1:0]  mon_next;
  logic [DOY_W-1:0]    day_wide;
  epc_cal_t            cal_next;

  // backpressure: a stage moves when it is empty or the next one moves
  always_comb begin
    en[LAST] = !v[LAST] || dn_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // year estimate from below: (e - 1) / 366
  always_comb begin
    prod4   = (2*DAYS_W)'(em1_0) * (2*DAYS_W)'(RECIP_366);
    j0_next = prod4[SHIFT_366 +: YIDX_W];
    j0_inc  = j0_1 + YIDX_W'(1);
  end

  // estimate is low by at most one year: settle it and take the day of year
  always_comb begin
    take_hi = off_hi2 < e2;
    j_sel   = take_hi ? (j0_2 + YIDX_W'(1)) : j0_2;
    off_sel = take_hi ? off_hi2 : off_lo2;
    t_wide  = (DAYS_W+1)'(e2) + (DAYS_W+1)'(MARCH_SHIFT) - (DAYS_W+1)'(off_sel);
  end

  // month of the march-based year: last boundary below the day
  always_comb begin
    mon_next = MONTH_W'(1);
    for (int m = 2; m <= MONTHS; m++) begin
      if (t3 > MONTH_START[m]) mon_next = MONTH_W'(m);
    end
  end

  // day of month and move to january-based months
  always_comb begin
    day_wide        = t4 - MONTH_START[mon4];
    cal_next.day    = day_wide[DAY_W-1:0];
    cal_next.hour   = tod4.hour;
    cal_next.minute = tod4.minute;
    cal_next.second = tod4.second;
    if (mon4 > MONTH_W'(MONTHS - MONTH_SHIFT)) begin
      cal_next.month = mon4 - MONTH_W'(MONTHS - MONTH_SHIFT);
      cal_next.year  = yr4 + YEAR_W'(1);
    end else begin
      cal_next.month = mon4 + MONTH_W'(MONTH_SHIFT);
      cal_next.year  = yr4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tod0  <= tod;
      e0    <= tod.days + DAY_BIAS;
      em1_0 <= tod.days + DAY_BIAS - DAYS_W'(1);
    end
    if (en[1]) begin
      tod1 <= tod0;
      e1   <= e0;
      j0_1 <= j0_next;
    end
    if (en[2]) begin
      tod2    <= tod1;
      e2      <= e1;
      j0_2    <= j0_1;
      off_lo2 <= YEAR_OFF[j0_1];
      off_hi2 <= YEAR_OFF[j0_inc];
    end
    if (en[3]) begin
      tod3 <= tod2;
      yr3  <= YEAR_W'(SEARCH_START_YEAR) + YEAR_W'(j_sel);
      t3   <= t_wide[DOY_W-1:0];
    end
    if (en[4]) begin
      tod4 <= tod3;
      yr4  <= yr3;
      t4   <= t3;
      mon4 <= mon_next;
    end
    if (en[5]) cal5 <= cal_next;
  end

  assign up_ready = en[0];
  assign dn_valid = v[LAST];
  assign cal      = cal5;

  // checks
  `EPC_ASSERT_NXT(a_enter, up_valid && up_ready, v[0], "accepted word did not enter the pipe")
  `EPC_ASSERT_IMP(a_drain_ready, !dn_valid, up_ready, "empty output stage but input stalled")
  `EPC_ASSERT_IMP(a_year_pick, v[2], off_lo2 < e2, "year estimate above the true year")
  `EPC_ASSERT_IMP(a_date_range, dn_valid,
                  (cal.month >= 4'd1) && (cal.month <= 4'd12) &&
                  (cal.day >= 5'd1) && (cal.day <= 5'd31),
                  "month or day out of range")

endmodule

[dv/tb_epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_core;
  import epc_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES   = 24;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned LAST_DAY      = 49710;

  // expected calendar words, oldest first, with their own prediction
  class calendar_scoreboard;
    typedef struct {
      logic [EPOCH_W-1:0] stamp;
      epc_cal_t           cal;
    } due_t;

    due_t        due_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // days from day zero of the common era to 1 march-based year y
    function int unsigned year_start_day(int unsigned y);
      return y * DAYS_PER_YEAR + y / 4 - y / 100 + y / 400;
    endfunction

    function epc_cal_t civil_from_epoch(logic [EPOCH_W-1:0] secs);
      int unsigned rest;
      int unsigned days;
      int unsigned yr;
      int unsigned mon;
      epc_cal_t    c;
      rest     = secs;
      c.second = SECOND_W'(rest % 60);
      rest     = rest / 60;
      c.minute = MINUTE_W'(rest % 60);
      rest     = rest / 60;
      c.hour   = HOUR_W'(rest % 24);
      rest     = rest / 24;
      days     = rest + ERA_OFFSET_DAYS;
      // march-based year by upward search
      yr = SEARCH_START_YEAR;
      while (days > year_start_day(yr + 1) + MARCH_SHIFT) yr++;
      days = days - year_start_day(yr);
      // month from the 367*m/12 boundaries
      mon = 1;
      while (mon < MONTHS && days > (MONTH_NUM * (mon + 1)) / 12) mon++;
      days  = days - (MONTH_NUM * mon) / 12;
      c.day = DAY_W'(days);
      // shift so that january is 1
      mon = mon + MONTH_SHIFT;
      if (mon > MONTHS) begin
        mon = mon - MONTHS;
        yr  = yr + 1;
      end
      c.month = MONTH_W'(mon);
      c.year  = YEAR_W'(yr);
      return c;
    endfunction

    function void note_stamp(logic [EPOCH_W-1:0] stamp);
      due_t d;
      d.stamp = stamp;
      d.cal   = civil_from_epoch(stamp);
      due_q.push_back(d);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_calendar(epc_cal_t got);
      due_t d;
      if (due_q.size() == 0) begin
        report($sformatf("calendar word %p with nothing outstanding", got));
      end else begin
        d = due_q.pop_front();
        if (got.year !== d.cal.year)
          report($sformatf("stamp %0d year %0d, want %0d", d.stamp, got.year, d.cal.year));
        if (got.month !== d.cal.month)
          report($sformatf("stamp %0d month %0d, want %0d", d.stamp, got.month, d.cal.month));
        if (got.day !== d.cal.day)
          report($sformatf("stamp %0d day %0d, want %0d", d.stamp, got.day, d.cal.day));
        if (got.hour !== d.cal.hour)
          report($sformatf("stamp %0d hour %0d, want %0d", d.stamp, got.hour, d.cal.hour));
        if (got.minute !== d.cal.minute)
          report($sformatf("stamp %0d minute %0d, want %0d",
                           d.stamp, got.minute, d.cal.minute));
        if (got.second !== d.cal.second)
          report($sformatf("stamp %0d second %0d, want %0d",
                           d.stamp, got.second, d.cal.second));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  epc_in_if  stamp_if ();
  epc_out_if cal_if ();

  calendar_scoreboard sb = new();

  bit          idle_on;
  bit          hold_req;
  int unsigned quiet_cycles;

  epoch_seconds_to_calendar_core u_top (
    .clk      (clk),
    .rst      (rst),
    .stamp    (stamp_if),
    .calendar (cal_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // output side: random back-pressure and one long hold on request
  initial begin
    bit hold_taken;
    hold_taken   = 1'b0;
    cal_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        cal_if.ready <= 1'b0;
        hold_taken = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        cal_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        cal_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // check every calendar word taken
  always @(posedge clk) begin
    if (!rst && cal_if.valid && cal_if.ready)
      sb.check_calendar(epc_cal_t'({cal_if.year, cal_if.month, cal_if.day,
                                    cal_if.hour, cal_if.minute, cal_if.second}));
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (stamp_if.valid && stamp_if.ready) || (cal_if.valid && cal_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout with %0d calendar words outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // offer one timestamp, with an optional idle burst first
  task send_stamp(logic [EPOCH_W-1:0] stamp);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      stamp_if.valid         <= 1'b0;
      stamp_if.epoch_seconds <= $urandom;
      repeat (gap) @(posedge clk);
    end
    stamp_if.valid         <= 1'b1;
    stamp_if.epoch_seconds <= stamp;
    do @(posedge clk); while (!stamp_if.ready);
    sb.note_stamp(stamp);
  endtask

  // stop offering until every calendar word is back
  task wait_for_calendars();
    stamp_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mix of full-range values, day edges, early and late stamps
  function logic [EPOCH_W-1:0] random_stamp();
    longint unsigned v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: begin
        v = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY;
        case ($urandom_range(0, 2))
          0: v = v + 0;
          1: v = v + SECS_PER_DAY - 1;
          default: v = v + $urandom_range(0, 3599);
        endcase
      end
      3: v = $urandom_range(0, 40000000);
      default: v = 64'hFFFF_FFFF - $urandom_range(0, 40000000);
    endcase
    return v[EPOCH_W-1:0];
  endfunction

  logic [EPOCH_W-1:0] directed [] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd5097599, 32'd5097600,        // end of february and first of march 1970
    32'd68169600,                    // leap day 1972
    32'd946684799, 32'd946684800,    // turn of the century 2000
    32'd951782400, 32'd951868800,    // leap day 2000 and the day after
    32'd2147483647, 32'd2147483648,  // signed 32-bit rollover
    32'd4107542399, 32'd4107542400,  // 2100 is not a leap year
    32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  initial begin
    rst                    = 1'b1;
    stamp_if.valid         = 1'b0;
    stamp_if.epoch_seconds = '0;
    idle_on                = 1'b1;
    hold_req               = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // field extremes and calendar corners
    foreach (directed[i]) send_stamp(directed[i]);
    wait_for_calendars();

    // long output hold while the input keeps offering, so the pipe backs up
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_stamp(random_stamp());
    wait_for_calendars();

    // random traffic with idling on both sides
    idle_on = 1'b1;
    repeat (650) send_stamp(random_stamp());
    wait_for_calendars();
    repeat (350) send_stamp(random_stamp());

    // closing stretch at full rate
    idle_on = 1'b0;
    repeat (290) send_stamp(random_stamp());
    wait_for_calendars();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d calendar words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
